/* rtl/pmsfd_pkg.sv */
// ---------------------------------------------------------------------------
// pmsfd_pkg: shared types and constants of the particulate frame decoder
// Holds the frame record that passes from the byte front end to the result
// back end, the configuration bundle, header bytes, limits and level scaling.
// ---------------------------------------------------------------------------
package pmsfd_pkg;

	localparam logic [7:0]  HDR0 = 8'h16;
	localparam logic [7:0]  HDR1 = 8'h11;
	localparam logic [7:0]  HDR2 = 8'h0B;
	localparam logic [15:0] VALUE_LIMIT = 16'd1001;
	localparam logic [15:0] CLASS_GOOD_BELOW = 16'd35;
	localparam logic [15:0] CLASS_MEDIUM_BELOW = 16'd85;

	// Status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_HEADER = 2'd1;
	localparam logic [1:0] ST_OVER = 2'd2;
	localparam logic [1:0] ST_SUM = 2'd3;

	// Quality classes.
	localparam logic [1:0] CLS_GOOD = 2'd0;
	localparam logic [1:0] CLS_MEDIUM = 2'd1;
	localparam logic [1:0] CLS_BAD = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_DIM = 2'd0;
	localparam logic [1:0] REG_HOLD = 2'd1;
	localparam logic [1:0] REG_SUM_CHECK = 2'd2;

	// Levels at the reset brightness of 100 percent.
	localparam logic [7:0] LEVEL_FULL = 8'd127;
	localparam logic [7:0] LEVEL_HALF = 8'd64;

	localparam int OUT_W = 40;

	typedef struct packed {
		logic        hdr_good;
		logic        sum_zero;
		logic [15:0] value;
	} frame_rec_t;

	typedef struct packed {
		logic [7:0] full_level;
		logic [7:0] half_level;
		logic       color_hold;
		logic       sum_check;
	} cfg_t;

	// base*dim/100 with saturation at 255. The product stays below 2^15, where
	// multiplying by 5243 and dropping 19 bits gives the exact quotient.
	function automatic logic [7:0] scale_level(input logic [14:0] prod);
		logic [27:0] wide;
		logic [8:0]  quot;
		wide = 28'(prod) * 28'd5243;
		quot = wide[27:19];
		return quot[8] ? 8'hFF : quot[7:0];
	endfunction

endpackage

/* rtl/pmsfd_front.sv */
// ---------------------------------------------------------------------------
// pmsfd_front: byte front end
// Tracks the frame position, header match, value bytes and running sum, and
// hands one frame record to the queue on the last byte of each frame.
// ---------------------------------------------------------------------------
module pmsfd_front
	import pmsfd_pkg::*;
#(
	parameter int FRAME_BYTES = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_start,
	input  logic       q_full,
	output logic       q_push,
	output frame_rec_t q_rec
);

	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

	logic [POS_W-1:0] pos_q;
	logic             hdr_good_q;
	logic [7:0]       val_hi_q;
	logic [7:0]       val_lo_q;
	logic [7:0]       sum_q;

	logic [POS_W-1:0] pos;
	logic             accept;
	logic             is_last;
	logic             hdr_next;
	logic [7:0]       sum_next;
	logic [7:0]       hi_next;
	logic [7:0]       lo_next;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	// A start mark pulls the byte to position zero and drops a partial frame.
	assign pos = in_start ? '0 : pos_q;
	assign is_last = (pos >= LAST_POS);

	always_comb begin
		if (pos == '0) begin
			hdr_next = (in_byte == HDR0);
			sum_next = in_byte;
		end else begin
			hdr_next = hdr_good_q
				&& !(pos == POS_W'(1) && in_byte != HDR1)
				&& !(pos == POS_W'(2) && in_byte != HDR2);
			sum_next = sum_q + in_byte;
		end
		hi_next = (pos == POS_W'(5)) ? in_byte : val_hi_q;
		lo_next = (pos == POS_W'(6)) ? in_byte : val_lo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_good_q <= 1'b1;
			val_hi_q <= '0;
			val_lo_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			pos_q <= is_last ? '0 : pos + POS_W'(1);
			hdr_good_q <= hdr_next;
			val_hi_q <= hi_next;
			val_lo_q <= lo_next;
			sum_q <= sum_next;
		end
	end

	assign q_push = accept && is_last;
	assign q_rec.hdr_good = hdr_next;
	assign q_rec.sum_zero = (sum_next == 8'd0);
	assign q_rec.value = {hi_next, lo_next};

endmodule

/* rtl/pmsfd_fifo.sv */
// ---------------------------------------------------------------------------
// pmsfd_fifo: frame record queue
// A short register queue between the front end and the back end so that
// either side can stall without holding the other.
// ---------------------------------------------------------------------------
module pmsfd_fifo
	import pmsfd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_rec_t push_rec,
	output logic       full,
	input  logic       pop,
	output frame_rec_t pop_rec,
	output logic       empty
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	frame_rec_t       mem_q [DEPTH];
	logic [IDX_W-1:0] wr_q;
	logic [IDX_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_rec = mem_q[rd_q];

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= next_idx(wr_q);
			end
			if (pop) begin
				rd_q <= next_idx(rd_q);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + CNT_W'(1);
				2'b01: cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/pmsfd_back.sv */
// ---------------------------------------------------------------------------
// pmsfd_back: result back end
// Turns a frame record into status, class and LED levels and holds the
// packed result in the output register until the receiver takes it.
// ---------------------------------------------------------------------------
module pmsfd_back
	import pmsfd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             q_empty,
	input  frame_rec_t       q_rec,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	logic             valid_q;
	logic [OUT_W-1:0] data_q;

	logic [1:0] status;
	logic [1:0] cls;
	logic       upd;
	logic [7:0] red;
	logic [7:0] green;

	assign q_pop = !q_empty && (!valid_q || out_ready);

	always_comb begin
		// Header mismatch wins over a sum error, which wins over the limit.
		if (!q_rec.hdr_good) begin
			status = ST_HEADER;
		end else if (cfg.sum_check && !q_rec.sum_zero) begin
			status = ST_SUM;
		end else if (q_rec.value > VALUE_LIMIT) begin
			status = ST_OVER;
		end else begin
			status = ST_OK;
		end

		if (q_rec.value < CLASS_GOOD_BELOW) begin
			cls = CLS_GOOD;
		end else if (q_rec.value < CLASS_MEDIUM_BELOW) begin
			cls = CLS_MEDIUM;
		end else begin
			cls = CLS_BAD;
		end

		upd = (status == ST_OK) && !cfg.color_hold;
		red = '0;
		green = '0;
		if (upd) begin
			case (cls)
				CLS_GOOD: begin
					green = cfg.full_level;
				end
				CLS_MEDIUM: begin
					red = cfg.full_level;
					green = cfg.half_level;
				end
				default: begin
					red = cfg.full_level;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= {2'b00, 1'b0, green, red, upd, cls, q_rec.value, status};
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

/* rtl/pm_sensor_frame_decoder_core.sv */
// ---------------------------------------------------------------------------
// pm_sensor_frame_decoder_core: particulate sensor frame decoder
// Assembles sensor bytes into fixed-length frames and reports one decoded
// result per frame with status, particle value, class and LED levels.
// ---------------------------------------------------------------------------
// Usage:
// Bytes enter on the s_ stream, one request per byte; s_tuser set marks a
// byte as the first of a frame and abandons any partial frame. Without the
// mark, frames follow one another every FRAME_BYTES bytes.
// The last byte of a frame produces one request on the m_ stream; all other
// bytes produce nothing. A byte is taken every cycle while the record queue
// has room, so throughput is one byte per cycle.
// The last byte of a frame writes its record into the record queue; from there
// it moves into the output register, which raises m_tvalid, once that
// register is empty or its result is being taken.
// When the receiver holds m_tready low the output register keeps its result,
// the record queue fills and only then does s_tready fall.
// Configuration writes on cfg_ are always taken (cfg_ready is high); the LED
// levels are scaled from the dim percentage when it is written.
// Reset clears the position, the queue and the output valid, and sets the
// dim percentage to 100, color hold off and checksum checking off.
// ---------------------------------------------------------------------------
module pm_sensor_frame_decoder_core
	import pmsfd_pkg::*;
#(
	parameter int FRAME_BYTES = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] rx_byte
	input  logic             s_tuser,   // [0] frame_start
	output logic             m_tvalid,
	input  logic             m_tready,
	// [1:0] frame_status, [17:2] particle_value, [19:18] quality_class,
	// [20] led_update, [28:21] red_level, [36:29] green_level, [37] blue_level
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data
);

	cfg_t       cfg_q;
	logic       q_full;
	logic       q_empty;
	logic       q_push;
	logic       q_pop;
	frame_rec_t push_rec;
	frame_rec_t pop_rec;
	logic [14:0] dim_full;
	logic [14:0] dim_half;

	assign cfg_ready = 1'b1;

	// 127*dim as a shift and subtract, 64*dim as a shift.
	assign dim_full = {cfg_data, 7'd0} - 15'(cfg_data);
	assign dim_half = {1'b0, cfg_data, 6'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_level <= LEVEL_FULL;
			cfg_q.half_level <= LEVEL_HALF;
			cfg_q.color_hold <= 1'b0;
			cfg_q.sum_check <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DIM: begin
					cfg_q.full_level <= scale_level(dim_full);
					cfg_q.half_level <= scale_level(dim_half);
				end
				REG_HOLD: cfg_q.color_hold <= cfg_data[0];
				REG_SUM_CHECK: cfg_q.sum_check <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pmsfd_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_byte (s_tdata),
		.in_start(s_tuser),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_rec   (push_rec)
	);

	pmsfd_fifo #(
		.DEPTH(4)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_rec(push_rec),
		.full    (q_full),
		.pop     (q_pop),
		.pop_rec (pop_rec),
		.empty   (q_empty)
	);

	pmsfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_rec    (pop_rec),
		.q_pop    (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata)
	);

endmodule
